### rtl/inode_bitmap_allocator_unit_assert.svh
// Assertion macros used by the allocator top level.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef INODE_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH
`define INODE_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define IBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define IBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/iba_pkg.sv
// Types, codes and constants for the bitmap slot allocator.
// Used by iba_ctrl, iba_dpath and inode_bitmap_allocator_unit; no dependencies.
package iba_pkg;

  localparam int unsigned MapWordsDefault = 32;
  localparam int unsigned WordBits        = 32;
  localparam int unsigned SlotW           = 10;
  localparam int unsigned CountW          = 11;
  localparam int unsigned BitPosW         = 5;
  localparam logic [WordBits-1:0] RootWord = 32'h8000_0000;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_ROOT     = 2'd2,
    ST_NOT_USED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_LOOK   = 2'd1,
    S_MODIFY = 2'd2
  } ctrl_state_e;

  typedef struct packed {
    op_e              operation;
    logic [SlotW-1:0] slot_index;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [SlotW-1:0]  granted_index;
    logic [CountW-1:0] used_count;
    logic [CountW-1:0] free_count;
  } rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic lookup;
    logic commit;
  } ctrl_cmd_t;

endpackage

### rtl/inode_bitmap_allocator_unit.sv
// Top level of the bitmap first-fit slot allocator.
// Depends on iba_pkg, iba_ctrl, iba_dpath and inode_bitmap_allocator_unit_assert.svh.
//
// Usage:
//   Request channel: drive req_i and raise start; the transfer happens at the
//   rising edge where start is high and busy is low. operation OP_ALLOC takes
//   the lowest free slot, OP_FREE releases req_i.slot_index.
//   Result channel: done_o pulses for one cycle with res_o valid. The receiver
//   cannot stall it; sample it in that cycle.
//   A request passes through word lookup (word-full summary vector plus one
//   memory read) and the single-port write-back of the modified word; busy
//   stays high until then, so a new request is taken only after the last
//   one is through. A new request may be accepted in the same cycle that
//   done_o is shown.
//   Reset: asynchronous, active low. Slot 0 (the root) is used, all other
//   slots free, used count 1, free count MAP_WORDS*32-1 (11 bits). Bitmap
//   words are tracked by valid flops, so no clearing pass is needed.
//   Root slot frees are refused; freeing a free or out-of-range slot reports
//   ST_NOT_USED and changes nothing.
`include "inode_bitmap_allocator_unit_assert.svh"

module inode_bitmap_allocator_unit
  import iba_pkg::*;
#(
  parameter int unsigned MAP_WORDS = MapWordsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t res_o
);

  localparam logic [CountW-1:0] TotalSlots = CountW'(MAP_WORDS * WordBits);

  ctrl_cmd_t cmd;

  // Sequence each request through lookup and write-back.
  iba_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd),
    .done_o (done_o)
  );

  // Hold the bitmap, counters and result register.
  iba_dpath #(
    .MAP_WORDS (MAP_WORDS)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .rsp_o  (res_o)
  );

  `IBA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `IBA_ASSERT_NOW(a_done_idle, done_o, !busy, "result shown while still busy")
  `IBA_ASSERT_NOW(a_done_after_busy, done_o, $past(busy), "result without a request in flight")
  `IBA_ASSERT_NOW(a_count_sum, done_o, CountW'(res_o.used_count + res_o.free_count) == TotalSlots, "used plus free counts lost a slot")
  `IBA_ASSERT_NOW(a_grant_zero, done_o && res_o.status != ST_DONE, res_o.granted_index == '0, "granted index nonzero on a refused request")

endmodule

### rtl/iba_ctrl.sv
// Sequencer of the allocator: idle, word lookup, read-modify-write.
// Depends on iba_pkg.
module iba_ctrl
  import iba_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  output ctrl_cmd_t cmd_o,
  output logic      done_o
);

  ctrl_state_e state_q, state_d;
  logic        done_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (start) state_d = S_LOOK;
      S_LOOK:   state_d = S_MODIFY;
      S_MODIFY: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.capture = start;
        busy          = 1'b0;
      end
      S_LOOK:   cmd_o.lookup = 1'b1;
      S_MODIFY: cmd_o.commit = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.commit;
    end
  end

  assign done_o = done_q;

endmodule

### rtl/iba_dpath.sv
// Datapath of the allocator: bitmap memory, word-full summary, counters, result register.
// Depends on iba_pkg; sequenced by iba_ctrl through ctrl_cmd_t.
module iba_dpath
  import iba_pkg::*;
#(
  parameter int unsigned MAP_WORDS = MapWordsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctrl_cmd_t cmd_i,
  input  req_t      req_i,
  output rsp_t      rsp_o
);

  localparam int unsigned AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  logic [WordBits-1:0]  mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] vld_q;
  logic [MAP_WORDS-1:0] full_q;

  req_t                req_q;
  logic [AW-1:0]       look_addr, waddr_q;
  logic                look_hit, hit_q;
  logic [WordBits-1:0] rd_data_q;
  logic                rd_vld_q;
  logic [CountW-1:0]   used_q, used_d, free_q, free_d;
  rsp_t                rsp_q, rsp_d;

  logic [WordBits-1:0] word, new_word, free_mask, alloc_mask;
  logic [BitPosW-1:0]  alloc_pos;
  logic                wr_en;

  // Pick the first word with a clear bit, or the word named by a free request.
  always_comb begin
    look_hit  = 1'b0;
    look_addr = '0;
    for (int i = MAP_WORDS - 1; i >= 0; i--) begin
      if (!full_q[i]) begin
        look_hit  = 1'b1;
        look_addr = AW'(i);
      end
    end
    if (req_q.operation == OP_FREE) begin
      look_hit  = 32'(req_q.slot_index[SlotW-1:BitPosW]) < MAP_WORDS;
      look_addr = AW'(req_q.slot_index[SlotW-1:BitPosW]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) req_q <= req_i;
    if (cmd_i.lookup) begin
      rd_data_q <= mem[look_addr];
      waddr_q   <= look_addr;
      hit_q     <= look_hit;
    end
    if (wr_en) mem[waddr_q] <= new_word;
    if (cmd_i.commit) rsp_q <= rsp_d;
  end

  // Unwritten words read as their reset value.
  assign word = rd_vld_q ? rd_data_q : ((waddr_q == '0) ? RootWord : '0);

  always_comb begin
    alloc_pos = '0;
    for (int b = WordBits - 1; b >= 0; b--) begin
      if (!word[WordBits-1-b]) alloc_pos = BitPosW'(b);
    end
  end

  assign alloc_mask = RootWord >> alloc_pos;
  assign free_mask  = RootWord >> req_q.slot_index[BitPosW-1:0];

  always_comb begin
    rsp_d    = '0;
    new_word = word;
    wr_en    = 1'b0;
    used_d   = used_q;
    free_d   = free_q;
    if (req_q.operation == OP_ALLOC) begin
      if (!hit_q) begin
        rsp_d.status = ST_FULL;
      end else begin
        rsp_d.status        = ST_DONE;
        rsp_d.granted_index = SlotW'({waddr_q, alloc_pos});
        new_word            = word | alloc_mask;
        wr_en               = cmd_i.commit;
        used_d              = used_q + CountW'(1);
        free_d              = free_q - CountW'(1);
      end
    end else if (req_q.slot_index == '0) begin
      rsp_d.status = ST_ROOT;
    end else if (!hit_q || ((word & free_mask) == '0)) begin
      rsp_d.status = ST_NOT_USED;
    end else begin
      rsp_d.status = ST_DONE;
      new_word     = word & ~free_mask;
      wr_en        = cmd_i.commit;
      used_d       = used_q - CountW'(1);
      free_d       = free_q + CountW'(1);
    end
    rsp_d.used_count = used_d;
    rsp_d.free_count = free_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      full_q   <= '0;
      rd_vld_q <= 1'b0;
      used_q   <= CountW'(1);
      free_q   <= CountW'(MAP_WORDS * WordBits - 1);
    end else begin
      if (cmd_i.lookup) rd_vld_q <= vld_q[look_addr];
      if (wr_en) begin
        vld_q[waddr_q]  <= 1'b1;
        full_q[waddr_q] <= (new_word == '1);
      end
      if (cmd_i.commit) begin
        used_q <= used_d;
        free_q <= free_d;
      end
    end
  end

  assign rsp_o = rsp_q;

endmodule

### tb/inode_bitmap_allocator_unit_test.sv
// Self-checking testbench for inode_bitmap_allocator_unit: directed and random
// allocate/free transfers, predicted by a slot ledger class and checked per result.
// Depends on iba_pkg and the allocator RTL only.
module inode_bitmap_allocator_unit_test
  import iba_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MapWords    = MapWordsDefault;
  localparam int unsigned MapSlots    = MapWords * WordBits;
  localparam int unsigned RandItems   = 1450;
  localparam int unsigned LimitCycles = 200000;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned TailCycles  = 6;

  // Slot ledger: mirrors the bitmap and counters, and queues the result each
  // accepted request must produce.
  class slot_ledger;
    logic [WordBits-1:0] used_map [MapWords];
    logic [CountW-1:0]   used_total;
    logic [CountW-1:0]   free_total;
    rsp_t                awaited_rsp [$];
    int                  mismatches;

    function new();
      foreach (used_map[w]) used_map[w] = '0;
      used_map[0] = RootWord;
      used_total  = CountW'(1);
      free_total  = CountW'(MapSlots - 1);
      mismatches  = 0;
    endfunction

    // Apply one request to the mirror and return the result it yields.
    function rsp_t predict_slot_op(req_t r);
      rsp_t                e;
      int unsigned         w;
      int unsigned         b;
      logic [WordBits-1:0] m;
      bit                  found;
      e.status        = ST_DONE;
      e.granted_index = '0;
      found           = 1'b0;
      if (r.operation == OP_ALLOC) begin
        for (w = 0; w < MapWords && !found; w++) begin
          if (used_map[w] != '1) begin
            for (b = 0; b < WordBits && !found; b++) begin
              m = RootWord >> b;
              if ((used_map[w] & m) == '0) begin
                used_map[w]     |= m;
                used_total       = used_total + CountW'(1);
                free_total       = free_total - CountW'(1);
                e.granted_index  = SlotW'(w * WordBits + b);
                found            = 1'b1;
              end
            end
          end
        end
        if (!found) e.status = ST_FULL;
      end else if (r.slot_index == '0) begin
        e.status = ST_ROOT;
      end else begin
        w = r.slot_index / WordBits;
        m = RootWord >> (r.slot_index % WordBits);
        if (w >= MapWords || (used_map[w] & m) == '0) begin
          e.status = ST_NOT_USED;
        end else begin
          used_map[w] &= ~m;
          used_total   = used_total - CountW'(1);
          free_total   = free_total + CountW'(1);
        end
      end
      e.used_count = used_total;
      e.free_count = free_total;
      return e;
    endfunction

    function void note_request(req_t r);
      awaited_rsp.push_back(predict_slot_op(r));
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      if (awaited_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: status=%0d granted=%0d used=%0d free=%0d",
                   $realtime, got.status, got.granted_index, got.used_count,
                   got.free_count);
        return;
      end
      e = awaited_rsp.pop_front();
      if (got.status !== e.status || got.granted_index !== e.granted_index ||
          got.used_count !== e.used_count || got.free_count !== e.free_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"[%0t] result mismatch: status exp %0d got %0d, granted exp %0d got %0d,",
                    " used exp %0d got %0d, free exp %0d got %0d"},
                   $realtime, e.status, got.status, e.granted_index, got.granted_index,
                   e.used_count, got.used_count, e.free_count, got.free_count);
      end
    endfunction

    // First used non-root slot at or after a given point, wrapping; 0 if none.
    function logic [SlotW-1:0] find_used(int unsigned from);
      int unsigned s;
      for (int unsigned k = 0; k < MapSlots; k++) begin
        s = (from + k) % MapSlots;
        if (s != 0 && (used_map[s / WordBits] & (RootWord >> (s % WordBits))) != '0)
          return SlotW'(s);
      end
      return '0;
    endfunction

    function int unsigned pending();
      return awaited_rsp.size();
    endfunction

    function int unsigned free_slots();
      return free_total;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req;
  logic done_o;
  rsp_t res_o;

  slot_ledger  ledger;
  int unsigned cycles;

  inode_bitmap_allocator_unit #(
    .MAP_WORDS(MapWords)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req),
    .done_o(done_o),
    .res_o (res_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Monitor: sample both channels at the rising edge. A result shown in the
  // same cycle as a new request belongs to an older transfer, so check first.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) ledger.check_result(res_o);
      if (start && !busy) ledger.note_request(req);
    end
  end

  // Watchdog: stop a hung run well beyond the slowest legal run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LimitCycles) begin
      $display("inode_bitmap_allocator_unit_test: FAIL");
      $finish;
    end
  end

  function automatic req_t make_req(op_e op, logic [SlotW-1:0] idx);
    req_t r;
    r.operation  = op;
    r.slot_index = idx;
    return r;
  endfunction

  // Present one request from a falling edge and hold it until the transfer
  // happens; return on the next falling edge with start still high.
  task automatic send_request(input req_t r);
    start = 1'b1;
    req   = r;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // Drop start for a number of cycles, with junk on the request bus.
  task automatic idle_for(input int unsigned n);
    if (n > 0) begin
      start = 1'b0;
      repeat (n) begin
        req = make_req(op_e'($urandom_range(0, 1)), SlotW'($urandom_range(0, MapSlots - 1)));
        @(negedge clk_i);
      end
    end
  endtask

  // Hold off until every predicted result has come back.
  task automatic wait_drained();
    start = 1'b0;
    while (ledger.pending() != 0) @(negedge clk_i);
  endtask

  // Random request. Frees mostly target a slot in use; the rest hit the root
  // or any index at all.
  function automatic req_t random_req(int unsigned alloc_pct);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < alloc_pct)
      return make_req(OP_ALLOC, SlotW'($urandom_range(0, MapSlots - 1)));
    pick = $urandom_range(0, 99);
    if (pick < 75) return make_req(OP_FREE, ledger.find_used($urandom_range(0, MapSlots - 1)));
    if (pick < 85) return make_req(OP_FREE, '0);
    return make_req(OP_FREE, SlotW'($urandom_range(0, MapSlots - 1)));
  endfunction

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned alloc_pct;
    int unsigned full_hits;
    ledger = new();
    cycles = 0;
    rst_ni = 1'b0;
    start  = 1'b0;
    req    = make_req(OP_ALLOC, '0);
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: first grants, root protection, double free, lowest-fit reuse,
    // top index and the ignored index on allocate.
    send_request(make_req(OP_ALLOC, '0));
    send_request(make_req(OP_ALLOC, '1));
    send_request(make_req(OP_ALLOC, '0));
    send_request(make_req(OP_FREE,  '0));
    send_request(make_req(OP_FREE,  10'd2));
    send_request(make_req(OP_FREE,  10'd2));
    send_request(make_req(OP_ALLOC, '1));
    send_request(make_req(OP_FREE,  '1));
    send_request(make_req(OP_FREE,  10'd31));
    send_request(make_req(OP_FREE,  10'd32));
    send_request(make_req(OP_FREE,  10'd1));
    send_request(make_req(OP_ALLOC, 10'd512));
    for (int i = 0; i < 30; i++) send_request(make_req(OP_ALLOC, '0));
    send_request(make_req(OP_FREE,  10'd31));
    send_request(make_req(OP_FREE,  10'd32));
    send_request(make_req(OP_ALLOC, '0));
    send_request(make_req(OP_ALLOC, '0));
    send_request(make_req(OP_FREE,  10'd1023));
    wait_drained();

    // Random: fill the map until it reports full a number of times, then
    // drain it with a free-heavy mix.
    sent      = 0;
    full_hits = 0;
    alloc_pct = 94;
    while (sent < RandItems) begin
      burst = $urandom_range(1, 20);
      for (int unsigned i = 0; i < burst && sent < RandItems; i++) begin
        if (alloc_pct == 94 && ledger.free_slots() == 0) begin
          full_hits++;
          if (full_hits > 25) alloc_pct = 35;
        end
        send_request(random_req(alloc_pct));
        sent++;
      end
      if ($urandom_range(0, 49) == 0) wait_drained();
      else if ($urandom_range(0, 2) == 0) idle_for(0);
      else idle_for($urandom_range(1, 6));
    end

    // Wait out outstanding results, then let the block settle.
    start = 1'b0;
    while (ledger.pending() != 0) @(negedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("inode_bitmap_allocator_unit_test: PASS");
    end else begin
      $display("inode_bitmap_allocator_unit_test: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/iba_pkg.sv
rtl/iba_ctrl.sv
rtl/iba_dpath.sv
rtl/inode_bitmap_allocator_unit.sv
tb/inode_bitmap_allocator_unit_test.sv
